[design/bgauge_pkg.sv]
`default_nettype none
package bgauge_pkg;

  localparam int MV_W        = 16;
  localparam int PCT_W       = 8;
  localparam int DIV_W       = 11;
  localparam int CNT_W       = $clog2(MV_W + 1);
  localparam int K_W         = 4;
  localparam int BASE_W      = 7;
  localparam int CURVE_POINTS = 11;

  localparam int CELL_COUNT  = 2;

  localparam logic [MV_W-1:0]  HYST_MV     = 16'd75;
  localparam logic [PCT_W-1:0] UNKNOWN_PCT = 8'hFF;
  localparam logic [PCT_W-1:0] FULL_PCT    = 8'd100;
  localparam logic [PCT_W-1:0] EMPTY_PCT   = 8'd0;
  localparam int               SEG_PCT     = 10;

  localparam logic [DIV_W-1:0] CurveMv [CURVE_POINTS] = '{
    11'd1500, 11'd1400, 11'd1350, 11'd1300, 11'd1275, 11'd1250,
    11'd1220, 11'd1190, 11'd1150, 11'd1100, 11'd1000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEG,
    ST_DIV2,
    ST_PCT,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic set_unknown;
    logic div_step;
    logic seg;
    logic pct_from_div;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic zero;
    logic div_busy;
    logic seg_direct;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[design/bgauge_ctrl.sv]
`default_nettype none
module bgauge_ctrl
  import bgauge_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts_i.take || sts_i.zero) state_d = ST_COMMIT;
        else state_d = ST_SEG;
      end
      ST_SEG: begin
        if (sts_i.seg_direct) state_d = ST_COMMIT;
        else state_d = ST_DIV2;
      end
      ST_DIV2: begin
        if (!sts_i.div_busy) state_d = ST_PCT;
      end
      ST_PCT: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.set_unknown = sts_i.take && sts_i.zero;
      end
      ST_SEG: begin
        cmd_o.seg = 1'b1;
      end
      ST_DIV2: begin
        cmd_o.div_step = sts_i.div_busy;
      end
      ST_PCT: begin
        cmd_o.pct_from_div = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/bgauge_dp.sv]
`default_nettype none
module bgauge_dp
  import bgauge_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [MV_W-1:0]  reading_mv_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [MV_W-1:0]       level_mv_o,
  output logic [PCT_W-1:0]      level_percent_o,
  output logic                  changed_o
);

  logic [MV_W-1:0]   r_q;
  logic [MV_W-1:0]   held_mv_q;
  logic [PCT_W-1:0]  held_pct_q;
  logic [PCT_W-1:0]  pct_q;
  logic [BASE_W-1:0] base_q, base_d;
  logic [DIV_W-1:0]  rem_q, div_q;
  logic [MV_W-1:0]   quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  logic [MV_W-1:0]   out_mv_q;
  logic [PCT_W-1:0]  out_pct_q;
  logic              out_chg_q;

  logic              take;
  logic [MV_W-1:0]   r_minus;
  logic [DIV_W:0]    trial;
  logic              ge;
  logic [MV_W-1:0]   cell_mv;
  logic              cell_hi, cell_lo;
  logic [DIV_W-1:0]  span_d, pos_d;
  logic [MV_W-1:0]   pos10;

  assign r_minus = r_q - HYST_MV;
  assign take    = (r_q < held_mv_q) || (r_q < HYST_MV) || (r_minus > held_mv_q);

  assign trial = {rem_q, quo_q[MV_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  assign cell_mv = r_q / MV_W'(CELL_COUNT);
  assign cell_hi = cell_mv >= MV_W'(CurveMv[0]);
  assign cell_lo = cell_mv <= MV_W'(CurveMv[CURVE_POINTS-1]);

  always_comb begin
    span_d = '0;
    pos_d  = '0;
    base_d = '0;
    for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
      if (cell_mv > MV_W'(CurveMv[k])) begin
        span_d = CurveMv[k-1] - CurveMv[k];
        pos_d  = cell_mv[DIV_W-1:0] - CurveMv[k];
        base_d = BASE_W'(100 - SEG_PCT * k);
      end
    end
  end

  assign pos10 = (MV_W'(pos_d) << 3) + (MV_W'(pos_d) << 1);

  assign sts_o.take       = take;
  assign sts_o.zero       = (r_q == '0);
  assign sts_o.div_busy   = (cnt_q != '0);
  assign sts_o.seg_direct = cell_hi || cell_lo;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) r_q <= reading_mv_i;
    if (cmd_i.set_unknown) pct_q <= UNKNOWN_PCT;
    if (cmd_i.seg && cell_hi) pct_q <= FULL_PCT;
    if (cmd_i.seg && !cell_hi && cell_lo) pct_q <= EMPTY_PCT;
    if (cmd_i.pct_from_div) pct_q <= PCT_W'(base_q) + quo_q[PCT_W-1:0];
    if (cmd_i.seg) base_q <= base_d;
    if (cmd_i.seg) begin
      rem_q <= '0;
      quo_q <= pos10;
      div_q <= span_d;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
      quo_q <= {quo_q[MV_W-2:0], ge};
    end
    if (cmd_i.commit) begin
      out_mv_q  <= take ? r_q : held_mv_q;
      out_pct_q <= take ? pct_q : held_pct_q;
      out_chg_q <= take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      held_mv_q   <= '0;
      held_pct_q  <= UNKNOWN_PCT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.seg && !(cell_hi || cell_lo)) begin
        cnt_q <= CNT_W'(MV_W);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.commit && take) begin
        held_mv_q  <= r_q;
        held_pct_q <= pct_q;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_mv_o      = out_mv_q;
  assign level_percent_o = out_pct_q;
  assign changed_o       = out_chg_q;

endmodule
`default_nettype wire

[design/battery_gauge_with_hysteresis.sv]
`default_nettype none
// Battery gauge with hysteresis: each accepted reading word yields one result word holding
// the held voltage, its charge percent (255 when the voltage is zero) and a changed flag.
// A reading is taken when it is below the held voltage, below 75 mV, or more than 75 mV
// above it. The per-cell voltage is a constant divide; a taken reading on a sloped part of
// the curve passes check, segment, a 16-step bit-serial divide for the interpolation,
// percent and commit; a taken reading at either end of the curve skips divide and percent,
// a rejected or zero reading goes from check to commit. The next reading is accepted once
// the result is in the output register; a stalled output holds the block until it leaves.
module battery_gauge_with_hysteresis
  import bgauge_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [MV_W-1:0]  reading_mv_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [MV_W-1:0]       level_mv_o,
  output logic [PCT_W-1:0]      level_percent_o,
  output logic                  changed_o
);

  cmd_t cmd;
  sts_t sts;

  bgauge_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bgauge_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .reading_mv_i    (reading_mv_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_mv_o      (level_mv_o),
    .level_percent_o (level_percent_o),
    .changed_o       (changed_o)
  );

endmodule
`default_nettype wire
